/* hw/rtl/uvs_pkg.sv */
// Shared constants, types and arithmetic helpers of the UV sphere vertex generator.
package uvs_pkg;

    // Division counts and the grid index range.
    localparam int MAX_DIVISIONS = 1024;
    localparam int DIV_W         = 11;

    // Angle datapath: CORDIC depth and its arctangent table.
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int STEP_W        = $clog2(ATAN_ENTRIES);
    localparam int ANG_W         = 34;

    // Long division: one quotient bit per cell, plus the leading bit.
    localparam int DIV_STEPS = 32;
    localparam int QUO_W     = DIV_STEPS + 1;

    // Field widths.
    localparam int RAD_W  = 24;
    localparam int POS_W  = 25;
    localparam int NRM_W  = 16;
    localparam int TEX_W  = 15;
    localparam int PROD_W = NRM_W + RAD_W + 1;

    localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

    // Configuration register indexes.
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    // Quadrant codes of a turn angle.
    localparam logic [1:0] QUAD_1 = 2'd0;
    localparam logic [1:0] QUAD_2 = 2'd1;
    localparam logic [1:0] QUAD_3 = 2'd2;

    // State that one division cell hands to the next.
    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DIV_STEPS-1:0] low;
        logic [QUO_W-1:0]     quo;
    } t_div_state;

    // State that one CORDIC cell hands to the next.
    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_cordic_state;

    // Arctangent of 2^-k as a fraction of a full turn (2^32 per turn).
    function automatic logic signed [ANG_W-1:0] atan_turns(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            default: v = 32'h00000051;
        endcase
        return $signed({2'b00, v});
    endfunction

    // Round a Q2.30 value to Q1.15 and saturate.
    function automatic logic signed [NRM_W-1:0] q30_to_q15(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t < -34'sd32768) begin
            return 16'sh8000;
        end else if (t > 34'sd32767) begin
            return 16'sh7FFF;
        end else begin
            return t[NRM_W-1:0];
        end
    endfunction

    // Negate a Q1.15 value; minus one maps to the largest positive code.
    function automatic logic signed [NRM_W-1:0] neg_sat(input logic signed [NRM_W-1:0] v);
        if (v == 16'sh8000) begin
            return 16'sh7FFF;
        end else begin
            return -v;
        end
    endfunction

    // Scale a normal times radius product back to radius units and saturate.
    function automatic logic signed [POS_W-1:0] pos_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + 41'sd16384) >>> 15;
        if (t < -41'sd16777215) begin
            return -25'sd16777215;
        end else if (t > 41'sd16777215) begin
            return 25'sd16777215;
        end else begin
            return t[POS_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/uvs_div_cell.sv */
// One registered step of a restoring long division by a small divisor.
module uvs_div_cell import uvs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_divisor,
    input  t_div_state       i_state,
    output t_div_state       o_state
);

    logic [DIV_W:0] w_trial;
    logic           w_fit;
    t_div_state     n_state;
    t_div_state     r_state;

    // Bring in the next numerator bit and try one subtraction.
    always_comb begin
        w_trial       = {i_state.rem, i_state.low[DIV_STEPS-1]};
        w_fit         = (w_trial >= {1'b0, i_divisor});
        n_state.rem   = w_fit ? DIV_W'(w_trial - {1'b0, i_divisor}) : w_trial[DIV_W-1:0];
        n_state.low   = {i_state.low[DIV_STEPS-2:0], 1'b0};
        n_state.quo   = {i_state.quo[QUO_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

/* hw/rtl/uvs_cordic_cell.sv */
// One registered rotation step of a CORDIC sine and cosine chain.
module uvs_cordic_cell import uvs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_step,
    input  t_cordic_state     i_state,
    output t_cordic_state     o_state
);

    logic signed [ANG_W-1:0] w_dx;
    logic signed [ANG_W-1:0] w_dy;
    logic signed [ANG_W-1:0] w_atan;
    t_cordic_state           n_state;
    t_cordic_state           r_state;

    // Rotate toward the residual angle by the arctangent of 2^-step.
    always_comb begin
        w_dx   = $signed(i_state.y) >>> i_step;
        w_dy   = $signed(i_state.x) >>> i_step;
        w_atan = atan_turns(i_step);
        if (!i_state.z[ANG_W-1]) begin
            n_state.x = $signed(i_state.x) - w_dx;
            n_state.y = $signed(i_state.y) + w_dy;
            n_state.z = $signed(i_state.z) - w_atan;
        end else begin
            n_state.x = $signed(i_state.x) + w_dx;
            n_state.y = $signed(i_state.y) - w_dy;
            n_state.z = $signed(i_state.z) + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

/* hw/rtl/uv_sphere_vertex_generator_unit.sv */
// Top level of the UV sphere vertex generator: grid point in, two strip vertices out.
//
// Usage: each input transfer carries a stack index and a slice index. The block
// answers with two output transfers, first the vertex at the band's upper polar
// angle (o_is_last low), then the one a band lower (o_is_last high), each with
// position, unit normal and texture coordinates.
// The configuration channel writes radius (index 0), slice count (1) and stack
// count (2); it is always ready, and writes belong in idle periods only.
// The second vertex is shown in the next cycle when the receiver takes the first.
// The single output port, which carries two vertices per point, sets the pace:
// the pipeline takes a new grid point only while the output buffer is empty or
// sends its second vertex. The rest is one pipeline of cells (32 long division
// cells, then the CORDIC cells, then multiply and round stages).
// Reset clears every valid bit and loads radius 256, 16 slices and 16 stacks.
// When the receiver stalls, the whole pipeline holds and o_ready drops; it is
// low only while a vertex waits at the output.
module uv_sphere_vertex_generator_unit import uvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [RAD_W-1:0]        i_cfg_data,
    // grid points
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [DIV_W-2:0]        i_stack_index,
    input  logic [DIV_W-1:0]        i_slice_index,
    // vertices
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic signed [NRM_W-1:0] o_norm_x,
    output logic signed [NRM_W-1:0] o_norm_y,
    output logic signed [NRM_W-1:0] o_norm_z,
    output logic [TEX_W-1:0]        o_tex_s,
    output logic [TEX_W-1:0]        o_tex_t,
    output logic                    o_is_last
);

    // Division lanes: azimuth, two polar angles, three texture coordinates.
    localparam int LANES      = 6;
    localparam int L_THETA    = 0;
    localparam int L_RHO0     = 1;
    localparam int L_RHO1     = 2;
    localparam int L_TEXS     = 3;
    localparam int L_TEXT0    = 4;
    localparam int L_TEXT1    = 5;
    localparam int TRIG_LANES = 3;
    localparam int TEX_LANES  = 3;
    localparam int RHO_SHIFT  = 1;
    localparam int TEX_SHIFT  = DIV_STEPS - 14;

    logic w_en;

    // ------------------------------------------------------------------
    // Configuration registers and clamped division counts.
    logic [RAD_W-1:0] r_radius;
    logic [DIV_W-1:0] r_slice_count;
    logic [DIV_W-1:0] r_stack_count;
    logic [DIV_W-1:0] w_slices;
    logic [DIV_W-1:0] w_stacks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RAD_W'(256);
            r_slice_count <= DIV_W'(16);
            r_stack_count <= DIV_W'(16);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIUS: r_radius      <= i_cfg_data;
                REG_SLICES: r_slice_count <= i_cfg_data[DIV_W-1:0];
                REG_STACKS: r_stack_count <= i_cfg_data[DIV_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_slice_count == '0) begin
            w_slices = DIV_W'(1);
        end else if (r_slice_count > DIV_W'(MAX_DIVISIONS)) begin
            w_slices = DIV_W'(MAX_DIVISIONS);
        end else begin
            w_slices = r_slice_count;
        end
        if (r_stack_count == '0) begin
            w_stacks = DIV_W'(1);
        end else if (r_stack_count > DIV_W'(MAX_DIVISIONS)) begin
            w_stacks = DIV_W'(MAX_DIVISIONS);
        end else begin
            w_stacks = r_stack_count;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: clamp the indexes and form the division numerators.
    logic [DIV_W-1:0] w_ic;
    logic [DIV_W-1:0] w_jc;
    logic             r_s0_vld;
    logic             r_s0_wrap;
    logic [DIV_W-1:0] r_s0_num [LANES];

    assign o_ready = w_en;

    always_comb begin
        if (DIV_W'(i_stack_index) > w_stacks - DIV_W'(1)) begin
            w_ic = w_stacks - DIV_W'(1);
        end else begin
            w_ic = DIV_W'(i_stack_index);
        end
        if (i_slice_index > w_slices) begin
            w_jc = w_slices;
        end else begin
            w_jc = i_slice_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_wrap          <= (w_jc == w_slices);
            r_s0_num[L_THETA]  <= w_jc;
            r_s0_num[L_RHO0]   <= w_ic;
            r_s0_num[L_RHO1]   <= w_ic + DIV_W'(1);
            r_s0_num[L_TEXS]   <= w_jc;
            r_s0_num[L_TEXT0]  <= w_stacks - w_ic;
            r_s0_num[L_TEXT1]  <= w_stacks - w_ic - DIV_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Division chains. The numerator is num * 2^32 plus half the divisor,
    // shifted up so that every lane runs the same number of cells; the
    // quotient is shifted back down at the end.
    logic [DIV_W-1:0]     w_lane_dv  [LANES];
    logic [DIV_STEPS-1:0] w_lane_low [LANES];
    t_div_state           w_div_in   [LANES];
    t_div_state           w_div_chain[LANES][DIV_STEPS];
    logic                 w_fit0     [LANES];

    always_comb begin
        w_lane_dv[L_THETA]  = w_slices;
        w_lane_dv[L_RHO0]   = w_stacks;
        w_lane_dv[L_RHO1]   = w_stacks;
        w_lane_dv[L_TEXS]   = w_slices;
        w_lane_dv[L_TEXT0]  = w_stacks;
        w_lane_dv[L_TEXT1]  = w_stacks;
        w_lane_low[L_THETA] = DIV_STEPS'(w_slices >> 1);
        w_lane_low[L_RHO0]  = DIV_STEPS'(w_stacks >> 1) << RHO_SHIFT;
        w_lane_low[L_RHO1]  = DIV_STEPS'(w_stacks >> 1) << RHO_SHIFT;
        w_lane_low[L_TEXS]  = DIV_STEPS'(w_slices >> 1) << TEX_SHIFT;
        w_lane_low[L_TEXT0] = DIV_STEPS'(w_stacks >> 1) << TEX_SHIFT;
        w_lane_low[L_TEXT1] = DIV_STEPS'(w_stacks >> 1) << TEX_SHIFT;
        // A numerator equal to the divisor yields a leading quotient bit.
        for (int l = 0; l < LANES; l++) begin
            w_fit0[l]       = (r_s0_num[l] >= w_lane_dv[l]);
            w_div_in[l].rem = w_fit0[l] ? r_s0_num[l] - w_lane_dv[l] : r_s0_num[l];
            w_div_in[l].low = w_lane_low[l];
            w_div_in[l].quo = QUO_W'(w_fit0[l]);
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_div_lane
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_step
            t_div_state w_src;
            if (k == 0) begin : g_first
                assign w_src = w_div_in[l];
            end else begin : g_next
                assign w_src = w_div_chain[l][k-1];
            end
            uvs_div_cell u_cell (
                .i_clk     (i_clk),
                .i_en      (w_en),
                .i_divisor (w_lane_dv[l]),
                .i_state   (w_src),
                .o_state   (w_div_chain[l][k])
            );
        end
    end

    // Valid and wrap flags travel beside the division cells.
    logic [DIV_STEPS-1:0] r_dv_vld;
    logic [DIV_STEPS-1:0] r_dv_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else if (w_en) begin
            r_dv_vld <= {r_dv_vld[DIV_STEPS-2:0], r_s0_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_wrap <= {r_dv_wrap[DIV_STEPS-2:0], r_s0_wrap};
        end
    end

    // ------------------------------------------------------------------
    // Angles from the quotients; the azimuth is zero at the seam.
    logic [DIV_STEPS-1:0] w_phase [TRIG_LANES];
    logic [TEX_W-1:0]     w_tex   [TEX_LANES];
    t_cordic_state        w_cd_in [TRIG_LANES];
    t_cordic_state        w_cd_chain[TRIG_LANES][CORDIC_N];

    always_comb begin
        w_phase[0] = r_dv_wrap[DIV_STEPS-1] ? '0
                   : w_div_chain[L_THETA][DIV_STEPS-1].quo[DIV_STEPS-1:0];
        w_phase[1] = w_div_chain[L_RHO0][DIV_STEPS-1].quo[QUO_W-1:RHO_SHIFT];
        w_phase[2] = w_div_chain[L_RHO1][DIV_STEPS-1].quo[QUO_W-1:RHO_SHIFT];
        w_tex[0]   = w_div_chain[L_TEXS][DIV_STEPS-1].quo[QUO_W-1:TEX_SHIFT];
        w_tex[1]   = w_div_chain[L_TEXT0][DIV_STEPS-1].quo[QUO_W-1:TEX_SHIFT];
        w_tex[2]   = w_div_chain[L_TEXT1][DIV_STEPS-1].quo[QUO_W-1:TEX_SHIFT];
        for (int t = 0; t < TRIG_LANES; t++) begin
            w_cd_in[t].x = GAIN_Q30;
            w_cd_in[t].y = '0;
            w_cd_in[t].z = $signed(ANG_W'(w_phase[t][DIV_STEPS-3:0]));
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chains for the azimuth and both polar angles.
    for (genvar t = 0; t < TRIG_LANES; t++) begin : g_cd_lane
        for (genvar k = 0; k < CORDIC_N; k++) begin : g_cd_step
            t_cordic_state w_src;
            if (k == 0) begin : g_first
                assign w_src = w_cd_in[t];
            end else begin : g_next
                assign w_src = w_cd_chain[t][k-1];
            end
            uvs_cordic_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_step  (STEP_W'(k)),
                .i_state (w_src),
                .o_state (w_cd_chain[t][k])
            );
        end
    end

    // Quadrants and texture coordinates travel beside the CORDIC cells.
    logic [CORDIC_N-1:0] r_cd_vld;
    logic [1:0]          r_cd_quad [CORDIC_N][TRIG_LANES];
    logic [TEX_W-1:0]    r_cd_tex  [CORDIC_N][TEX_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld <= '0;
        end else if (w_en) begin
            r_cd_vld <= CORDIC_N'({r_cd_vld, r_dv_vld[DIV_STEPS-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < CORDIC_N; k++) begin
                for (int t = 0; t < TRIG_LANES; t++) begin
                    if (k == 0) begin
                        r_cd_quad[k][t] <= w_phase[t][DIV_STEPS-1:DIV_STEPS-2];
                        r_cd_tex[k][t]  <= w_tex[t];
                    end else begin
                        r_cd_quad[k][t] <= r_cd_quad[k-1][t];
                        r_cd_tex[k][t]  <= r_cd_tex[k-1][t];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reflect by quadrant and round to Q1.15.
    logic signed [ANG_W-1:0] w_rc [TRIG_LANES];
    logic signed [ANG_W-1:0] w_rs [TRIG_LANES];
    logic                    r_tr_vld;
    logic signed [NRM_W-1:0] r_tr_cos [TRIG_LANES];
    logic signed [NRM_W-1:0] r_tr_sin [TRIG_LANES];
    logic [TEX_W-1:0]        r_tr_tex [TEX_LANES];

    always_comb begin
        for (int t = 0; t < TRIG_LANES; t++) begin
            case (r_cd_quad[CORDIC_N-1][t])
                QUAD_1: begin
                    w_rc[t] = w_cd_chain[t][CORDIC_N-1].x;
                    w_rs[t] = w_cd_chain[t][CORDIC_N-1].y;
                end
                QUAD_2: begin
                    w_rc[t] = -w_cd_chain[t][CORDIC_N-1].y;
                    w_rs[t] = w_cd_chain[t][CORDIC_N-1].x;
                end
                QUAD_3: begin
                    w_rc[t] = -w_cd_chain[t][CORDIC_N-1].x;
                    w_rs[t] = -w_cd_chain[t][CORDIC_N-1].y;
                end
                default: begin
                    w_rc[t] = w_cd_chain[t][CORDIC_N-1].y;
                    w_rs[t] = -w_cd_chain[t][CORDIC_N-1].x;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Normal products, normal rounding, radius products.
    logic                    r_pm_vld;
    logic signed [31:0]      r_pm_ss  [2];
    logic signed [31:0]      r_pm_cs  [2];
    logic signed [NRM_W-1:0] r_pm_cr  [2];
    logic [TEX_W-1:0]        r_pm_tex [TEX_LANES];

    logic                    r_nv_vld;
    logic signed [NRM_W-1:0] r_nv_n   [2][3];
    logic [TEX_W-1:0]        r_nv_tex [TEX_LANES];

    logic                     r_rm_vld;
    logic signed [PROD_W-1:0] r_rm_p   [2][3];
    logic signed [NRM_W-1:0]  r_rm_n   [2][3];
    logic [TEX_W-1:0]         r_rm_tex [TEX_LANES];
    logic signed [RAD_W:0]    w_rad;

    assign w_rad = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_vld <= 1'b0;
            r_pm_vld <= 1'b0;
            r_nv_vld <= 1'b0;
            r_rm_vld <= 1'b0;
        end else if (w_en) begin
            r_tr_vld <= r_cd_vld[CORDIC_N-1];
            r_pm_vld <= r_tr_vld;
            r_nv_vld <= r_pm_vld;
            r_rm_vld <= r_nv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int t = 0; t < TRIG_LANES; t++) begin
                r_tr_cos[t] <= q30_to_q15(w_rc[t]);
                r_tr_sin[t] <= q30_to_q15(w_rs[t]);
            end
            for (int e = 0; e < 2; e++) begin
                r_pm_ss[e] <= r_tr_sin[0] * r_tr_sin[1+e];
                r_pm_cs[e] <= r_tr_cos[0] * r_tr_sin[1+e];
                r_pm_cr[e] <= r_tr_cos[1+e];
                r_nv_n[e][0] <= neg_sat(q30_to_q15(ANG_W'(r_pm_ss[e])));
                r_nv_n[e][1] <= q30_to_q15(ANG_W'(r_pm_cs[e]));
                r_nv_n[e][2] <= r_pm_cr[e];
                for (int a = 0; a < 3; a++) begin
                    r_rm_p[e][a] <= r_nv_n[e][a] * w_rad;
                    r_rm_n[e][a] <= r_nv_n[e][a];
                end
            end
            for (int t = 0; t < TEX_LANES; t++) begin
                r_tr_tex[t] <= r_cd_tex[CORDIC_N-1][t];
                r_pm_tex[t] <= r_tr_tex[t];
                r_nv_tex[t] <= r_pm_tex[t];
                r_rm_tex[t] <= r_nv_tex[t];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: holds both vertices of a point and sends them in order.
    logic                    r_ob_vld;
    logic                    r_ob_sel;
    logic signed [POS_W-1:0] r_ob_pos [2][3];
    logic signed [NRM_W-1:0] r_ob_nrm [2][3];
    logic [TEX_W-1:0]        r_ob_tex [TEX_LANES];

    // The pipeline moves when the buffer is empty or sends its second vertex.
    assign w_en = !r_ob_vld || (i_ready && r_ob_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_ob_sel <= 1'b0;
        end else if (w_en) begin
            r_ob_vld <= r_rm_vld;
            r_ob_sel <= 1'b0;
        end else if (i_ready) begin
            r_ob_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) begin
                for (int a = 0; a < 3; a++) begin
                    r_ob_pos[e][a] <= pos_round(r_rm_p[e][a]);
                    r_ob_nrm[e][a] <= r_rm_n[e][a];
                end
            end
            for (int t = 0; t < TEX_LANES; t++) begin
                r_ob_tex[t] <= r_rm_tex[t];
            end
        end
    end

    assign o_valid   = r_ob_vld;
    assign o_pos_x   = r_ob_pos[r_ob_sel][0];
    assign o_pos_y   = r_ob_pos[r_ob_sel][1];
    assign o_pos_z   = r_ob_pos[r_ob_sel][2];
    assign o_norm_x  = r_ob_nrm[r_ob_sel][0];
    assign o_norm_y  = r_ob_nrm[r_ob_sel][1];
    assign o_norm_z  = r_ob_nrm[r_ob_sel][2];
    assign o_tex_s   = r_ob_tex[0];
    assign o_tex_t   = r_ob_sel ? r_ob_tex[2] : r_ob_tex[1];
    assign o_is_last = r_ob_sel;

`ifndef NO_ASSERTIONS
    // The second vertex of a point follows right after the first is taken.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_is_last) |=> (o_valid && o_is_last))
        else $error("second vertex did not follow the first");

    // Input is held off only while a vertex waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no vertex pending");

    // Clamped division counts stay within the supported range.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_slices >= DIV_W'(1)) && (w_slices <= DIV_W'(MAX_DIVISIONS))
        && (w_stacks >= DIV_W'(1)) && (w_stacks <= DIV_W'(MAX_DIVISIONS)))
        else $error("division count out of range");

    // Texture coordinates never exceed one.
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tex_s <= TEX_W'(16384)) && (o_tex_t <= TEX_W'(16384)))
        else $error("texture coordinate above one");
`endif

endmodule

/* tb/uv_sphere_vertex_generator_unit_tb.sv */
// Self-checking testbench for the UV sphere vertex generator: predicts and compares both vertices.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_unit_tb import uvs_pkg::*; ();

    // Index that addresses no register.
    localparam logic [1:0] REG_NONE   = 2'd3;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         DRAIN_WAIT = 80;

    typedef struct packed {
        logic signed [POS_W-1:0] px, py, pz;
        logic signed [NRM_W-1:0] nx, ny, nz;
        logic [TEX_W-1:0]        ts, tt;
        logic                    last;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [RAD_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [DIV_W-2:0] i_stack_index = '0;
    logic [DIV_W-1:0] i_slice_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [NRM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic [TEX_W-1:0] o_tex_s, o_tex_t;
    logic o_is_last;

    uv_sphere_vertex_generator_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the registers and the queue of predicted vertices.
    longint  sh_radius = 256, sh_slices = 16, sh_stacks = 16;
    t_vertex vertex_queue[$];
    int      errors = 0;
    int      points_sent = 0;
    int      vertices_seen = 0;
    int      idle_cycles = 0;
    bit      hold_off = 1'b0;
    bit      rx_no_stall = 1'b0;
    bit      tx_no_gap = 1'b0;

    function automatic longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_q15(longint v);
        return clip(shr_floor(v + 16384, 15), -32768, 32767);
    endfunction

    function automatic longint turn_atan(int k);
        longint tbl[24] = '{
            'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
            'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051};
        return tbl[k];
    endfunction

    // Rotation CORDIC on a 32-bit turn angle, quadrant folded afterwards.
    task automatic cos_sin(input longint phase, output longint c, output longint s);
        longint x, y, z, dx, dy, rc, rs;
        logic [1:0] q;
        x = 652032874;
        y = 0;
        z = phase & 'h3FFFFFFF;
        q = 2'((phase >> 30) & 3);
        for (int k = 0; k < CORDIC_N; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= turn_atan(k);
            end else begin
                x += dx; y -= dy; z += turn_atan(k);
            end
        end
        case (q)
            QUAD_1: begin rc = x;  rs = y;  end
            QUAD_2: begin rc = -y; rs = x;  end
            QUAD_3: begin rc = -x; rs = -y; end
            default: begin rc = y; rs = -x; end
        endcase
        c = to_q15(rc);
        s = to_q15(rs);
    endtask

    function automatic longint div_clamp(longint v);
        return v == 0 ? 1 : (v > MAX_DIVISIONS ? MAX_DIVISIONS : v);
    endfunction

    function automatic longint scale_pos(longint n);
        return clip(shr_floor(n * sh_radius + 16384, 15), -16777215, 16777215);
    endfunction

    // Predict the two strip vertices of one grid point.
    task automatic predict_vertices(input longint si, input longint sj);
        longint slices, stacks, theta, rho, ct, st, cr, sr, nx, ny, tex_s, ii;
        t_vertex v;
        slices = div_clamp(sh_slices);
        stacks = div_clamp(sh_stacks);
        if (si > stacks - 1) si = stacks - 1;
        if (sj > slices) sj = slices;
        theta = (sj == slices) ? 0 : (((sj << 32) + (slices >> 1)) / slices) & 'hFFFFFFFF;
        cos_sin(theta, ct, st);
        tex_s = (sj * 16384 + (slices >> 1)) / slices;
        for (int e = 0; e < 2; e++) begin
            ii = si + e;
            rho = (((ii << 32) + stacks) / (2 * stacks)) & 'hFFFFFFFF;
            cos_sin(rho, cr, sr);
            nx = clip(-to_q15(st * sr), -32768, 32767);
            ny = to_q15(ct * sr);
            v.px = POS_W'(scale_pos(nx));
            v.py = POS_W'(scale_pos(ny));
            v.pz = POS_W'(scale_pos(cr));
            v.nx = NRM_W'(nx);
            v.ny = NRM_W'(ny);
            v.nz = NRM_W'(cr);
            v.ts = TEX_W'(tex_s);
            v.tt = TEX_W'(((stacks - ii) * 16384 + (stacks >> 1)) / stacks);
            v.last = e[0];
            vertex_queue = {vertex_queue, v};
        end
    endtask

    // Gap length: mostly short, sometimes long.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                           : int'($urandom_range(0, 2));
    endfunction

    // Send one grid point; the prediction is made at the transfer.
    // Valid drops only for a real gap, so points without a gap go back to back.
    task automatic send_point(input logic [DIV_W-2:0] si, input logic [DIV_W-1:0] sj,
                              input bit gaps);
        int g;
        g = gaps && !tx_no_gap ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_stack_index <= si;
        i_slice_index <= sj;
        do @(posedge i_clk); while (!o_ready);
        predict_vertices(longint'(si), longint'(sj));
        points_sent++;
    endtask

    // Wait until every predicted vertex is back, then let the pipeline settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [RAD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_RADIUS: sh_radius = longint'(data);
            REG_SLICES: sh_slices = longint'(data[DIV_W-1:0]);
            REG_STACKS: sh_stacks = longint'(data[DIV_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic configure(input longint rad, input longint sl, input longint st);
        wait_drained();
        write_reg(REG_RADIUS, rad[RAD_W-1:0]);
        write_reg(REG_SLICES, sl[RAD_W-1:0]);
        write_reg(REG_STACKS, st[RAD_W-1:0]);
    endtask

    // Directed: extremes of both indexes, wrap, clamping at reset settings.
    task automatic test_directed_reset_setup();
        send_point(0, 0, 0);
        send_point(15, 16, 0);
        send_point(8, 4, 0);
        send_point(1023, 2047, 0);
        send_point(16, 17, 0);
        send_point(7, 12, 0);
        send_point(10'h2AA, 11'h555, 0);
        send_point(10'h155, 11'h2AA, 0);
    endtask

    // Directed: zero and oversized division counts, out-of-range register index.
    task automatic test_directed_odd_counts();
        configure(0, 0, 0);
        write_reg(REG_NONE, 24'hFFFFFF);
        send_point(0, 0, 0);
        send_point(5, 1, 0);
        configure(24'hFFFFFF, 2047, 2047);
        send_point(0, 0, 0);
        send_point(1023, 1024, 0);
        send_point(1023, 2047, 0);
        send_point(512, 256, 0);
        configure(24'hFFFFFF, 1024, 1024);
        send_point(1023, 1023, 0);
        send_point(0, 1024, 0);
        configure(1, 1, 1);
        send_point(0, 0, 0);
        send_point(0, 1, 0);
        configure(256, 3, 2);
        send_point(1, 2, 0);
    endtask

    // Random grid points under a few register settings.
    task automatic test_random_points(input int count);
        longint sl, st;
        for (int n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                case ($urandom_range(0, 3))
                    0: configure($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 32),
                                 $urandom_range(1, 32));
                    1: configure($urandom_range(0, 4096), $urandom_range(0, 2047),
                                 $urandom_range(0, 2047));
                    2: configure(24'hFFFFFF, 1024, $urandom_range(1, 1024));
                    default: configure($urandom_range(0, 24'hFFFFFF),
                                       $urandom_range(1, 1024), $urandom_range(1, 1024));
                endcase
            end
            sl = div_clamp(sh_slices);
            st = div_clamp(sh_stacks);
            if ($urandom_range(0, 7) == 0)
                send_point(10'($urandom_range(0, 1023)), 11'($urandom_range(0, 2047)), 1);
            else
                send_point(10'($urandom_range(0, int'(st) - 1)),
                           11'($urandom_range(0, int'(sl))), 1);
        end
    endtask

    // Receiver holds off long while the sender keeps offering points.
    task automatic test_back_pressure();
        tx_no_gap = 1'b1;
        hold_off = 1'b1;
        for (int n = 0; n < 80; n++)
            send_point(10'($urandom_range(0, 1023)), 11'($urandom_range(0, 2047)), 0);
        tx_no_gap = 1'b0;
        wait_drained();
    endtask

    // Full-rate stretch with neither side idling.
    task automatic test_full_rate();
        rx_no_stall = 1'b1;
        tx_no_gap = 1'b1;
        for (int n = 0; n < 40; n++)
            send_point(10'($urandom_range(0, 1023)), 11'($urandom_range(0, 2047)), 0);
        wait_drained();
        rx_no_stall = 1'b0;
        tx_no_gap = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int s;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            s = rx_no_stall ? 0 : gap_len();
            if (s > 0) begin
                i_ready <= 1'b0;
                repeat (s) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare every vertex transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_valid && i_ready) begin
            vertices_seen++;
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex transfer", $time);
                errors++;
            end else begin
                want = vertex_queue.pop_front();
                if ({o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z, o_tex_s,
                     o_tex_t, o_is_last} !== want) begin
                    errors++;
                    $display("%0t: mismatch expected pos %0d %0d %0d nrm %0d %0d %0d tex %0d %0d last %0b",
                             $time, want.px, want.py, want.pz, want.nx, want.ny, want.nz,
                             want.ts, want.tt, want.last);
                    $display("%0t:          actual pos %0d %0d %0d nrm %0d %0d %0d tex %0d %0d last %0b",
                             $time, o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z,
                             o_tex_s, o_tex_t, o_is_last);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_reset_setup();
        test_directed_odd_counts();
        test_back_pressure();
        test_full_rate();
        test_random_points(310);
        wait_drained();
        $display("Sent %0d grid points and checked %0d vertices over several radius and",
                 points_sent, vertices_seen);
        $display("division settings, including clamped indexes, stalls and full-rate bursts.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
